### rtl/sfmb_pkg.sv
// shared types, protocol codes and crc function for the stuffed frame memory bridge
`default_nettype none

package sfmb_pkg;

    // framing bytes and escape codes
    localparam logic [7:0] START_BYTE  = 8'hFE;
    localparam logic [7:0] ESCAPE_BYTE = 8'h1B;
    localparam logic [7:0] CODE_START  = 8'h01;
    localparam logic [7:0] CODE_END    = 8'h02;
    localparam logic [7:0] CODE_ESCAPE = 8'h03;

    // command and reply identifiers
    localparam logic [7:0] CMD_WRITE  = 8'h10;
    localparam logic [7:0] CMD_READ   = 8'h11;
    localparam logic [7:0] REPLY_READ = 8'h12;

    // frame lengths
    localparam int WRITE_LENGTH    = 10;
    localparam int READ_MIN_LENGTH = 5;

    // only command, address and data bytes are ever read back
    localparam int STORE_DEPTH = 9;
    localparam int STORE_IDX_W = 4;

    // byte counter saturates at the top of its range
    localparam int            COUNT_W   = 11;
    localparam logic [10:0]   COUNT_MAX = 11'h7FF;

    localparam int            LIMIT_W     = 10;
    localparam logic [9:0]    LIMIT_RESET = 10'd200;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TX    = 2'd2;

    // reply sequencer states
    typedef enum logic [2:0] {
        TX_IDLE,
        TX_SOF,
        TX_ID,
        TX_DATA,
        TX_CRC,
        TX_ESC,
        TX_END
    } t_tx_state;

    // memory request leaving the frame parser
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] write_word;
        logic        read_pending;
    } t_rx_out;

    // reply byte leaving the sequencer
    typedef struct packed {
        logic       busy;
        logic       valid;
        logic [7:0] tx_byte;
        logic       last;
    } t_tx_out;

    // crc-8 maxim, reflected polynomial 0x31, one byte
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ 8'h8C;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // crc after the reply identifier byte
    localparam logic [7:0] REPLY_CRC_INIT = crc_byte(8'h00, REPLY_READ);

endpackage

`default_nettype wire

### rtl/sfmb_rx.sv
// receive frame parser: unstuffing, running crc, command decode and lockout
`default_nettype none

module sfmb_rx #(
    parameter int FRAME_DEPTH = 11
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rx_take,    // accepted serial byte
    input  wire logic [7:0]                  i_rx_byte,
    input  wire logic                        i_reply_take, // accepted read data for pending read
    input  wire logic [sfmb_pkg::LIMIT_W-1:0] i_limit,
    output sfmb_pkg::t_rx_out                o_rx
);

    localparam int LEN_W = $clog2(FRAME_DEPTH + 1);

    logic [LEN_W-1:0]              r_len, n_len;
    logic                          r_esc, n_esc;
    logic                          r_pend, n_pend;
    logic                          r_lock, n_lock;
    logic [sfmb_pkg::COUNT_W-1:0]  r_cnt, n_cnt;
    logic [7:0]                    r_crc, n_crc;
    logic [7:0]                    r_store [sfmb_pkg::STORE_DEPTH];

    logic [sfmb_pkg::COUNT_W-1:0]  cnt_inc;
    logic                          store_en;
    logic [7:0]                    store_val;
    logic                          req_valid;
    logic [1:0]                    req_kind;

    always_comb begin
        n_len     = r_len;
        n_esc     = r_esc;
        n_crc     = r_crc;
        n_pend    = r_pend;
        n_lock    = r_lock;
        n_cnt     = r_cnt;
        store_en  = 1'b0;
        store_val = i_rx_byte;
        req_valid = 1'b0;
        req_kind  = sfmb_pkg::KIND_WRITE;
        cnt_inc   = (r_cnt == sfmb_pkg::COUNT_MAX) ? r_cnt : r_cnt + 1'b1;

        if (i_reply_take) begin
            n_pend = 1'b0;
        end

        if (i_rx_take && !r_lock && !r_pend) begin
            n_cnt = cnt_inc;
            priority if (cnt_inc > {1'b0, i_limit}) begin
                n_lock = 1'b1;
                n_len  = '0;
                n_esc  = 1'b0;
                n_crc  = '0;
            end else if (r_len >= LEN_W'(FRAME_DEPTH)) begin
                // overlong frame, byte dropped
                n_len = '0;
                n_esc = 1'b0;
                n_crc = '0;
            end else if (i_rx_byte == sfmb_pkg::ESCAPE_BYTE) begin
                n_esc = 1'b1;
            end else if (r_esc) begin
                n_esc = 1'b0;
                priority if (i_rx_byte == sfmb_pkg::CODE_START) begin
                    store_en  = 1'b1;
                    store_val = sfmb_pkg::START_BYTE;
                end else if (i_rx_byte == sfmb_pkg::CODE_ESCAPE) begin
                    store_en  = 1'b1;
                    store_val = sfmb_pkg::ESCAPE_BYTE;
                end else if (i_rx_byte == sfmb_pkg::CODE_END) begin
                    // end of frame: check and decode
                    n_len = '0;
                    n_crc = '0;
                    if (r_len != '0 && r_crc == 8'h00) begin
                        if (r_store[0] == sfmb_pkg::CMD_WRITE &&
                            r_len == LEN_W'(sfmb_pkg::WRITE_LENGTH)) begin
                            req_valid = 1'b1;
                            req_kind  = sfmb_pkg::KIND_WRITE;
                            n_cnt     = '0;
                        end else if (r_store[0] == sfmb_pkg::CMD_READ &&
                                     r_len >= LEN_W'(sfmb_pkg::READ_MIN_LENGTH)) begin
                            req_valid = 1'b1;
                            req_kind  = sfmb_pkg::KIND_READ;
                            n_pend    = 1'b1;
                            n_cnt     = '0;
                        end
                    end
                end else begin
                    // bad escape code
                    n_len = '0;
                    n_crc = '0;
                end
            end else if (i_rx_byte == sfmb_pkg::START_BYTE) begin
                n_len = '0;
                n_esc = 1'b0;
                n_crc = '0;
            end else begin
                store_en = 1'b1;
            end
        end

        if (store_en) begin
            n_len = r_len + 1'b1;
            n_crc = sfmb_pkg::crc_byte(r_crc, store_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_esc  <= 1'b0;
            r_pend <= 1'b0;
            r_lock <= 1'b0;
            r_cnt  <= '0;
            r_crc  <= '0;
        end else begin
            r_len  <= n_len;
            r_esc  <= n_esc;
            r_pend <= n_pend;
            r_lock <= n_lock;
            r_cnt  <= n_cnt;
            r_crc  <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_en && r_len < LEN_W'(sfmb_pkg::STORE_DEPTH)) begin
            r_store[r_len[sfmb_pkg::STORE_IDX_W-1:0]] <= store_val;
        end
    end

    always_comb begin
        o_rx.valid        = req_valid;
        o_rx.kind         = req_kind;
        o_rx.address      = {r_store[4], r_store[3], r_store[2], r_store[1]};
        o_rx.write_word   = (req_kind == sfmb_pkg::KIND_WRITE)
                          ? {r_store[8], r_store[7], r_store[6], r_store[5]} : 32'h0;
        o_rx.read_pending = r_pend;
    end

endmodule

`default_nettype wire

### rtl/sfmb_tx.sv
// reply frame sequencer: stuffs and sends the read data with its crc
`default_nettype none

module sfmb_tx (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_word,
    input  wire logic        i_ready,  // output register can take a byte
    output sfmb_pkg::t_tx_out o_tx
);

    sfmb_pkg::t_tx_state r_state, n_state;
    logic [31:0]         r_word;
    logic [1:0]          r_idx, n_idx;
    logic                r_stuffed, n_stuffed;
    logic [7:0]          r_crc, n_crc;

    logic [7:0]          cur_byte;
    logic                needs_stuff;

    always_comb begin
        cur_byte    = (r_state == sfmb_pkg::TX_CRC) ? r_crc : r_word[8*r_idx +: 8];
        needs_stuff = (cur_byte == sfmb_pkg::START_BYTE) ||
                      (cur_byte == sfmb_pkg::ESCAPE_BYTE);
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_stuffed = r_stuffed;
        n_crc     = r_crc;
        unique case (r_state)
            sfmb_pkg::TX_IDLE: begin
                if (i_start) begin
                    n_state   = sfmb_pkg::TX_SOF;
                    n_idx     = '0;
                    n_stuffed = 1'b0;
                    n_crc     = sfmb_pkg::REPLY_CRC_INIT;
                end
            end
            sfmb_pkg::TX_SOF: begin
                if (i_ready) n_state = sfmb_pkg::TX_ID;
            end
            sfmb_pkg::TX_ID: begin
                if (i_ready) n_state = sfmb_pkg::TX_DATA;
            end
            sfmb_pkg::TX_DATA, sfmb_pkg::TX_CRC: begin
                if (i_ready) begin
                    if (!r_stuffed && needs_stuff) begin
                        n_stuffed = 1'b1;
                    end else begin
                        n_stuffed = 1'b0;
                        if (r_state == sfmb_pkg::TX_CRC) begin
                            n_state = sfmb_pkg::TX_ESC;
                        end else begin
                            n_crc = sfmb_pkg::crc_byte(r_crc, cur_byte);
                            if (r_idx == 2'd3) begin
                                n_state = sfmb_pkg::TX_CRC;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                    end
                end
            end
            sfmb_pkg::TX_ESC: begin
                if (i_ready) n_state = sfmb_pkg::TX_END;
            end
            sfmb_pkg::TX_END: begin
                if (i_ready) n_state = sfmb_pkg::TX_IDLE;
            end
            default: n_state = sfmb_pkg::TX_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_tx.busy    = (r_state != sfmb_pkg::TX_IDLE);
        o_tx.valid   = (r_state != sfmb_pkg::TX_IDLE);
        o_tx.tx_byte = 8'h00;
        o_tx.last    = 1'b0;
        unique case (r_state)
            sfmb_pkg::TX_IDLE: o_tx.tx_byte = 8'h00;
            sfmb_pkg::TX_SOF:  o_tx.tx_byte = sfmb_pkg::START_BYTE;
            sfmb_pkg::TX_ID:   o_tx.tx_byte = sfmb_pkg::REPLY_READ;
            sfmb_pkg::TX_DATA, sfmb_pkg::TX_CRC: begin
                if (r_stuffed) begin
                    o_tx.tx_byte = (cur_byte == sfmb_pkg::START_BYTE)
                                 ? sfmb_pkg::CODE_START : sfmb_pkg::CODE_ESCAPE;
                end else if (needs_stuff) begin
                    o_tx.tx_byte = sfmb_pkg::ESCAPE_BYTE;
                end else begin
                    o_tx.tx_byte = cur_byte;
                end
            end
            sfmb_pkg::TX_ESC:  o_tx.tx_byte = sfmb_pkg::ESCAPE_BYTE;
            sfmb_pkg::TX_END: begin
                o_tx.tx_byte = sfmb_pkg::CODE_END;
                o_tx.last    = 1'b1;
            end
            default: o_tx.tx_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sfmb_pkg::TX_IDLE;
            r_idx     <= '0;
            r_stuffed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_stuffed <= n_stuffed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        if (r_state == sfmb_pkg::TX_IDLE && i_start) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

### rtl/stuffed_frame_memory_bridge.sv
// top level: byte-stuffed serial frames to memory requests and stuffed read replies
//
// channel   dir  handshake                   payload
// s         in   i_s_tvalid / o_s_tready     tdata {read_word, rx_byte}, tuser command
// m         out  o_m_tvalid / i_m_tready     tdata {tx_byte, write_word, address},
//                                            tuser kind, tlast last
// cfg       in   i_cfg_valid / o_cfg_ready   bad_byte_limit
//
// a serial byte is decoded in the cycle it is taken; a request lands in the
//   output register at that edge; a byte per cycle unless replying or stalled
// read data starts the reply sequencer, which sends 9 to 14 bytes, one per
//   cycle the output register frees; no item is taken until the last one leaves
// synchronous active-low reset clears the frame, lockout, pending read and
//   the limit (back to 200); the byte store is not cleared
// a stalled output holds its item; input is taken again as soon as it drains
`default_nettype none

module stuffed_frame_memory_bridge #(
    parameter int FRAME_DEPTH = 11
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // [7:0] rx_byte, [39:8] read_word
    input  wire logic        i_s_tuser,   // [0] command

    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [71:0] o_m_tdata,   // [31:0] address, [63:32] write_word, [71:64] tx_byte
    output      logic [1:0]  o_m_tuser,   // [1:0] kind
    output      logic        o_m_tlast,

    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [9:0]  i_cfg_data   // [9:0] bad_byte_limit
);

    // config register
    logic [sfmb_pkg::LIMIT_W-1:0] r_limit;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [31:0] r_out_addr;
    logic [31:0] r_out_wword;
    logic [7:0]  r_out_tx;
    logic        r_out_last;

    sfmb_pkg::t_rx_out w_rx;
    sfmb_pkg::t_tx_out w_tx;

    logic out_free;
    logic in_take;
    logic rx_take;
    logic reply_start;

    // output register can load when empty or being drained
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_s_tready  = out_free && !w_tx.busy;
    assign in_take     = i_s_tvalid && o_s_tready;
    assign rx_take     = in_take && !i_s_tuser;
    // read data with no pending read is dropped
    assign reply_start = in_take && i_s_tuser && w_rx.read_pending;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= sfmb_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    sfmb_rx #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_take    (rx_take),
        .i_rx_byte    (i_s_tdata[7:0]),
        .i_reply_take (reply_start),
        .i_limit      (r_limit),
        .o_rx         (w_rx)
    );

    sfmb_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (reply_start),
        .i_word  (i_s_tdata[39:8]),
        .i_ready (out_free),
        .o_tx    (w_tx)
    );

    // a reply byte and a request never compete: input waits while replying
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= w_tx.valid || w_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (w_tx.valid) begin
                r_out_kind  <= sfmb_pkg::KIND_TX;
                r_out_addr  <= 32'h0;
                r_out_wword <= 32'h0;
                r_out_tx    <= w_tx.tx_byte;
                r_out_last  <= w_tx.last;
            end else if (w_rx.valid) begin
                r_out_kind  <= w_rx.kind;
                r_out_addr  <= w_rx.address;
                r_out_wword <= w_rx.write_word;
                r_out_tx    <= 8'h00;
                r_out_last  <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_tx, r_out_wword, r_out_addr};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    // a request and a reply byte are never produced in the same cycle
    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_tx.valid && w_rx.valid))
        else $error("request and reply byte collide");

    // accepted read data for a pending read starts the reply
    a_reply_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reply_start |=> (w_tx.busy && !w_rx.read_pending))
        else $error("reply did not start");

    // a read request leaves the receiver waiting for data
    a_read_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rx.valid && w_rx.kind == sfmb_pkg::KIND_READ) |=> w_rx.read_pending)
        else $error("read request without pending read");

    // every request reaches the output register
    a_req_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rx.valid |=> (r_out_valid && r_out_last && r_out_kind != sfmb_pkg::KIND_TX))
        else $error("request lost");

endmodule

`default_nettype wire

### verif/tb_stuffed_frame_memory_bridge.sv
// self-checking testbench for the stuffed frame memory bridge
`timescale 1ns / 100ps

module tb_stuffed_frame_memory_bridge;

    localparam int          FRAME_DEPTH  = 11;
    localparam int          IDLE_GAP     = 40;         // cycles left for work that makes no item
    localparam int          HOLD_CYCLES  = 400;        // long receiver hold-off
    localparam int          IDLE_PCT     = 28;
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;

    typedef logic [7:0] t_byte_q[$];

    typedef enum logic [1:0] {
        FRAME_CLEAN,
        FRAME_BAD_CRC,
        FRAME_DOUBLE_ESC
    } t_frame_mode;

    // one item leaving the master side
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] write_word;
        logic [7:0]  tx_byte;
        logic        last;
    } t_bridge_item;

    // frame decoder and reply builder, plus the queue of items still to come
    class frame_bridge_scoreboard;
        logic [7:0]   frame_bytes[FRAME_DEPTH];
        int unsigned  frame_len;
        bit           esc_seen;
        bit           read_wait;
        bit           rx_locked;
        logic [10:0]  byte_count;
        logic [7:0]   crc_acc;
        logic [9:0]   lock_limit;
        t_bridge_item awaited[$];
        int unsigned  mismatch_count;

        function new();
            frame_len      = 0;
            esc_seen       = 1'b0;
            read_wait      = 1'b0;
            rx_locked      = 1'b0;
            byte_count     = '0;
            crc_acc        = '0;
            lock_limit     = sfmb_pkg::LIMIT_RESET;
            mismatch_count = 0;
        endfunction

        // dallas crc-8, lsb first
        static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            repeat (8) c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
            return c;
        endfunction

        function void drop_frame();
            frame_len = 0;
            esc_seen  = 1'b0;
            crc_acc   = '0;
        endfunction

        function void keep_byte(logic [7:0] b);
            if (frame_len < FRAME_DEPTH) begin
                frame_bytes[frame_len] = b;
                frame_len++;
                crc_acc = crc8_step(crc_acc, b);
            end
        endfunction

        function logic [31:0] le_word(int unsigned first);
            logic [31:0] w;
            w = '0;
            for (int i = 0; i < 4; i++) begin
                if (first + i < frame_len && first + i < FRAME_DEPTH) begin
                    w[8*i +: 8] = frame_bytes[first + i];
                end
            end
            return w;
        endfunction

        function void push(logic [1:0] kind, logic [31:0] addr, logic [31:0] data,
                           logic [7:0] tx, logic last);
            t_bridge_item e;
            e.kind       = kind;
            e.address    = addr;
            e.write_word = data;
            e.tx_byte    = tx;
            e.last       = last;
            awaited.push_back(e);
        endfunction

        function void push_stuffed(logic [7:0] b);
            if (b == sfmb_pkg::START_BYTE) begin
                push(sfmb_pkg::KIND_TX, '0, '0, sfmb_pkg::ESCAPE_BYTE, 1'b0);
                push(sfmb_pkg::KIND_TX, '0, '0, sfmb_pkg::CODE_START, 1'b0);
            end else if (b == sfmb_pkg::ESCAPE_BYTE) begin
                push(sfmb_pkg::KIND_TX, '0, '0, sfmb_pkg::ESCAPE_BYTE, 1'b0);
                push(sfmb_pkg::KIND_TX, '0, '0, sfmb_pkg::CODE_ESCAPE, 1'b0);
            end else begin
                push(sfmb_pkg::KIND_TX, '0, '0, b, 1'b0);
            end
        endfunction

        // end mark seen: decide whether the stored frame is a good command
        function void close_frame();
            if (frame_len == 0 || crc_acc != 8'h00) begin
                drop_frame();
                return;
            end
            if (frame_bytes[0] == sfmb_pkg::CMD_WRITE &&
                frame_len == sfmb_pkg::WRITE_LENGTH) begin
                push(sfmb_pkg::KIND_WRITE, le_word(1), le_word(5), '0, 1'b1);
            end else if (frame_bytes[0] == sfmb_pkg::CMD_READ &&
                         frame_len >= sfmb_pkg::READ_MIN_LENGTH) begin
                push(sfmb_pkg::KIND_READ, le_word(1), '0, '0, 1'b1);
                read_wait = 1'b1;
            end else begin
                drop_frame();
                return;
            end
            drop_frame();
            byte_count = '0;
        endfunction

        function void take_serial_byte(logic [7:0] c);
            if (rx_locked || read_wait) return;
            if (byte_count < sfmb_pkg::COUNT_MAX) byte_count++;
            if (byte_count > {1'b0, lock_limit}) begin
                rx_locked = 1'b1;
                drop_frame();
                return;
            end
            if (frame_len >= FRAME_DEPTH) begin
                drop_frame();
                return;
            end
            if (c == sfmb_pkg::ESCAPE_BYTE) begin
                esc_seen = 1'b1;
                return;
            end
            if (esc_seen) begin
                esc_seen = 1'b0;
                case (c)
                    sfmb_pkg::CODE_START:  keep_byte(sfmb_pkg::START_BYTE);
                    sfmb_pkg::CODE_ESCAPE: keep_byte(sfmb_pkg::ESCAPE_BYTE);
                    sfmb_pkg::CODE_END:    close_frame();
                    default:               drop_frame();
                endcase
                return;
            end
            if (c == sfmb_pkg::START_BYTE) begin
                drop_frame();
            end else begin
                keep_byte(c);
            end
        endfunction

        function void build_read_reply(logic [31:0] word);
            logic [7:0] crc;
            logic [7:0] b;
            if (!read_wait) return;
            read_wait = 1'b0;
            drop_frame();
            push(sfmb_pkg::KIND_TX, '0, '0, sfmb_pkg::START_BYTE, 1'b0);
            push(sfmb_pkg::KIND_TX, '0, '0, sfmb_pkg::REPLY_READ, 1'b0);
            crc = crc8_step(8'h00, sfmb_pkg::REPLY_READ);
            for (int i = 0; i < 4; i++) begin
                b   = word[8*i +: 8];
                crc = crc8_step(crc, b);
                push_stuffed(b);
            end
            push_stuffed(crc);
            push(sfmb_pkg::KIND_TX, '0, '0, sfmb_pkg::ESCAPE_BYTE, 1'b0);
            push(sfmb_pkg::KIND_TX, '0, '0, sfmb_pkg::CODE_END, 1'b1);
        endfunction

        function void note_item(bit cmd, logic [7:0] rx, logic [31:0] word);
            if (!cmd) begin
                take_serial_byte(rx);
            end else begin
                build_read_reply(word);
            end
        endfunction

        function void check_item(t_bridge_item got);
            t_bridge_item want;
            if (awaited.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected output item: kind %0d addr %h data %h tx %h last %b",
                             got.kind, got.address, got.write_word, got.tx_byte, got.last);
                end
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.address !== want.address ||
                got.write_word !== want.write_word || got.tx_byte !== want.tx_byte ||
                got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("mismatch: expected kind %0d addr %h data %h tx %h last %b",
                             want.kind, want.address, want.write_word, want.tx_byte,
                             want.last);
                    $display("          got      kind %0d addr %h data %h tx %h last %b",
                             got.kind, got.address, got.write_word, got.tx_byte, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [39:0] i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [9:0]  i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [71:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        o_cfg_ready;

    frame_bridge_scoreboard sb = new();
    t_bridge_item           seen_item;
    int unsigned            items_sent = 0;
    bit                     quiet      = 1'b0;   // no idling on either side
    bit                     hold_ask   = 1'b0;
    int                     hold_left  = 0;

    stuffed_frame_memory_bridge #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // both handshakes sampled with the values present at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_item(i_s_tuser, i_s_tdata[7:0], i_s_tdata[39:8]);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_item.kind       = o_m_tuser;
            seen_item.address    = o_m_tdata[31:0];
            seen_item.write_word = o_m_tdata[63:32];
            seen_item.tx_byte    = o_m_tdata[71:64];
            seen_item.last       = o_m_tlast;
            sb.check_item(seen_item);
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_ask) begin
                hold_ask  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0:       return sfmb_pkg::START_BYTE;
            1:       return sfmb_pkg::ESCAPE_BYTE;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return r[7:0];
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    endfunction

    // command byte, little-endian address and data, then filler up to n_total - 1
    function automatic t_byte_q request_body(logic [7:0] cmd, logic [31:0] addr,
                                             logic [31:0] data, int n_total);
        t_byte_q     q;
        logic [63:0] tail;
        tail = {data, addr};
        q.push_back(cmd);
        for (int i = 0; i < n_total - 2; i++) begin
            q.push_back(i < 8 ? tail[8*i +: 8] : pick_byte());
        end
        return q;
    endfunction

    task automatic offer(input bit cmd, input logic [7:0] rx, input logic [31:0] word);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {word, rx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        offer(1'b0, b, $urandom);
    endtask

    task automatic answer_read(input logic [31:0] word);
        logic [31:0] r;
        r = $urandom;
        offer(1'b1, r[7:0], word);
    endtask

    task automatic put_stuffed(input logic [7:0] b);
        if (b == sfmb_pkg::START_BYTE) begin
            put_byte(sfmb_pkg::ESCAPE_BYTE);
            put_byte(sfmb_pkg::CODE_START);
        end else if (b == sfmb_pkg::ESCAPE_BYTE) begin
            put_byte(sfmb_pkg::ESCAPE_BYTE);
            put_byte(sfmb_pkg::CODE_ESCAPE);
        end else begin
            put_byte(b);
        end
    endtask

    task automatic send_frame(input t_byte_q body, input t_frame_mode mode);
        logic [7:0] crc;
        crc = 8'h00;
        foreach (body[i]) crc = frame_bridge_scoreboard::crc8_step(crc, body[i]);
        if (mode == FRAME_BAD_CRC) crc ^= 8'h01 << $urandom_range(7);
        put_byte(sfmb_pkg::START_BYTE);
        foreach (body[i]) put_stuffed(body[i]);
        put_stuffed(crc);
        put_byte(sfmb_pkg::ESCAPE_BYTE);
        // second escape keeps the escape pending, frame still ends cleanly
        if (mode == FRAME_DOUBLE_ESC) put_byte(sfmb_pkg::ESCAPE_BYTE);
        put_byte(sfmb_pkg::CODE_END);
    endtask

    task automatic send_empty();
        put_byte(sfmb_pkg::START_BYTE);
        put_byte(sfmb_pkg::ESCAPE_BYTE);
        put_byte(sfmb_pkg::CODE_END);
    endtask

    // partial frame broken by an escape followed by an unknown code
    task automatic send_bad_escape();
        logic [31:0] r;
        logic [7:0]  c;
        put_byte(sfmb_pkg::START_BYTE);
        repeat ($urandom_range(3)) put_byte(pick_byte());
        do begin
            r = $urandom;
            c = r[7:0];
        end while (c == sfmb_pkg::CODE_START || c == sfmb_pkg::CODE_END ||
                   c == sfmb_pkg::CODE_ESCAPE || c == sfmb_pkg::ESCAPE_BYTE);
        put_byte(sfmb_pkg::ESCAPE_BYTE);
        put_byte(c);
        put_byte(sfmb_pkg::ESCAPE_BYTE);
        put_byte(sfmb_pkg::CODE_END);
    endtask

    task automatic write_limit(input logic [9:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.lock_limit = value;
    endtask

    // close any pending read, drain all expected items, then let the block go quiet
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        if (sb.read_wait) begin
            answer_read(pick_word());
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic directed_cases();
        answer_read(32'hFFFF_FFFF);                 // read data with nothing pending
        put_byte(8'h00);
        put_byte(8'hFF);
        send_empty();
        send_frame(request_body(sfmb_pkg::CMD_WRITE, 32'hFFFF_FFFF, 32'h0000_0000,
                                sfmb_pkg::WRITE_LENGTH), FRAME_CLEAN);
        send_frame(request_body(sfmb_pkg::CMD_WRITE, 32'h1BFE_1BFE, 32'hFE1B_00FF,
                                sfmb_pkg::WRITE_LENGTH), FRAME_CLEAN);
        // a read, then a whole frame sent while that read is pending goes nowhere
        send_frame(request_body(sfmb_pkg::CMD_READ, 32'h0000_0000, 32'h0, 6), FRAME_CLEAN);
        send_frame(request_body(sfmb_pkg::CMD_WRITE, 32'h1234_5678, 32'h9ABC_DEF0,
                                sfmb_pkg::WRITE_LENGTH), FRAME_CLEAN);
        answer_read(32'hFE1B_FE1B);                 // every reply data byte stuffed
        send_frame(request_body(sfmb_pkg::CMD_READ, 32'hFFFF_FFFF, 32'h0,
                                sfmb_pkg::READ_MIN_LENGTH), FRAME_CLEAN);
        answer_read(32'h0000_0000);
        send_frame(request_body(sfmb_pkg::CMD_READ, 32'h8000_0001, 32'h7FFF_FFFE,
                                FRAME_DEPTH), FRAME_CLEAN);
        answer_read(32'hFFFF_FFFF);
        send_frame(request_body(sfmb_pkg::CMD_WRITE, pick_word(), pick_word(),
                                sfmb_pkg::WRITE_LENGTH), FRAME_BAD_CRC);
        send_frame(request_body(sfmb_pkg::REPLY_READ, pick_word(), pick_word(),
                                sfmb_pkg::WRITE_LENGTH), FRAME_CLEAN);
        send_frame(request_body(sfmb_pkg::CMD_WRITE, pick_word(), pick_word(),
                                sfmb_pkg::WRITE_LENGTH - 1), FRAME_CLEAN);
        send_frame(request_body(sfmb_pkg::CMD_READ, pick_word(), 32'h0,
                                sfmb_pkg::READ_MIN_LENGTH - 1), FRAME_CLEAN);
        send_frame(request_body(sfmb_pkg::CMD_WRITE, pick_word(), pick_word(),
                                FRAME_DEPTH + 1), FRAME_CLEAN);
        send_bad_escape();
        send_frame(request_body(sfmb_pkg::CMD_WRITE, 32'hA5A5_5A5A, 32'h0F0F_F0F0,
                                sfmb_pkg::WRITE_LENGTH), FRAME_DOUBLE_ESC);
        // start byte in the middle of a frame restarts it
        put_byte(sfmb_pkg::START_BYTE);
        put_byte(sfmb_pkg::CMD_WRITE);
        put_byte(8'h55);
        send_frame(request_body(sfmb_pkg::CMD_WRITE, 32'h0000_0001, 32'h8000_0000,
                                sfmb_pkg::WRITE_LENGTH), FRAME_CLEAN);
    endtask

    task automatic one_scenario();
        int unsigned pick;
        int          n;
        logic [31:0] r;
        logic [7:0]  cmd;
        pick = $urandom_range(99);
        if (pick < 35) begin
            send_frame(request_body(sfmb_pkg::CMD_WRITE, pick_word(), pick_word(),
                                    sfmb_pkg::WRITE_LENGTH),
                       ($urandom_range(9) == 0) ? FRAME_DOUBLE_ESC : FRAME_CLEAN);
        end else if (pick < 60) begin
            n = $urandom_range(FRAME_DEPTH, sfmb_pkg::READ_MIN_LENGTH);
            send_frame(request_body(sfmb_pkg::CMD_READ, pick_word(), 32'h0, n), FRAME_CLEAN);
            repeat ($urandom_range(2)) put_byte(pick_byte());
            answer_read(pick_word());
        end else if (pick < 68) begin
            cmd = $urandom_range(1) ? sfmb_pkg::CMD_WRITE : sfmb_pkg::CMD_READ;
            send_frame(request_body(cmd, pick_word(), pick_word(), sfmb_pkg::WRITE_LENGTH),
                       FRAME_BAD_CRC);
        end else if (pick < 74) begin
            // unknown command, or a known one with a length it does not take
            case ($urandom_range(2))
                0: begin
                    do begin
                        r   = $urandom;
                        cmd = r[7:0];
                    end while (cmd == sfmb_pkg::CMD_WRITE || cmd == sfmb_pkg::CMD_READ);
                    n = $urandom_range(FRAME_DEPTH, 2);
                end
                1: begin
                    cmd = sfmb_pkg::CMD_WRITE;
                    n   = $urandom_range(FRAME_DEPTH, 2);
                    if (n == sfmb_pkg::WRITE_LENGTH) n = sfmb_pkg::WRITE_LENGTH - 1;
                end
                default: begin
                    cmd = sfmb_pkg::CMD_READ;
                    n   = $urandom_range(sfmb_pkg::READ_MIN_LENGTH - 1, 2);
                end
            endcase
            send_frame(request_body(cmd, pick_word(), pick_word(), n), FRAME_CLEAN);
        end else if (pick < 80) begin
            n = FRAME_DEPTH + $urandom_range(2, 1);
            send_frame(request_body(sfmb_pkg::CMD_WRITE, pick_word(), pick_word(), n),
                       FRAME_CLEAN);
        end else if (pick < 85) begin
            send_bad_escape();
        end else if (pick < 90) begin
            send_empty();
        end else if (pick < 95) begin
            repeat ($urandom_range(6, 1)) put_byte(pick_byte());
        end else begin
            answer_read($urandom);
        end
    endtask

    task automatic random_traffic(input int unsigned n_items, input bit squeeze);
        int unsigned stop;
        int unsigned half;
        stop = items_sent + n_items;
        half = items_sent + n_items / 2;
        while (items_sent < stop) begin
            if (squeeze && items_sent >= half) begin
                hold_ask = 1'b1;
                squeeze  = 1'b0;
            end
            one_scenario();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_limit(10'h3FF);
        directed_cases();
        settle();

        quiet = 1'b1;
        random_traffic(60, 1'b0);
        quiet = 1'b0;
        random_traffic(90, 1'b1);
        settle();

        write_limit(10'($urandom_range(150, 60)));
        random_traffic(120, 1'b1);
        settle();

        // zero limit: the very first byte locks the receiver for good
        write_limit(10'h000);
        send_frame(request_body(sfmb_pkg::CMD_WRITE, pick_word(), pick_word(),
                                sfmb_pkg::WRITE_LENGTH), FRAME_CLEAN);
        send_frame(request_body(sfmb_pkg::CMD_READ, pick_word(), 32'h0, 6), FRAME_CLEAN);
        answer_read(pick_word());
        settle();

        if (sb.mismatch_count == 0 && sb.awaited.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
rtl/sfmb_pkg.sv
rtl/sfmb_rx.sv
rtl/sfmb_tx.sv
rtl/stuffed_frame_memory_bridge.sv
verif/tb_stuffed_frame_memory_bridge.sv
